FILE: hw/rtl/bir_pkg.sv
// Shared types and constants for the bilinear image resizer.
// Used by the frame store, the axis mapper, the blend unit and the top level; depends on nothing.
package bir_pkg;

    localparam int DIM_W   = 9;
    localparam int STEP_W  = 24;
    localparam int COORD_W = 16;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y        = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

endpackage

FILE: hw/rtl/bilinear_image_resize.sv
// Top level of the bilinear image resizer: configuration registers, query sequencer,
// frame store, two axis mappers and one shared blend unit. Uses bir_pkg and all bir_ modules.
//
//  Channel   Signals                                      Beat taken when
//  input     start, busy, opcode, column, row,            start && !busy
//            red_in, green_in, blue_in
//  result    done, red_out, green_out, blue_out, clamped  done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// A write beat leaves busy low. A query beat holds busy high through the clamp, read, bottom
// and vertical states while the single frame store read port fetches the four neighbours one
// per cycle; done, registered from the vertical state, pulses when busy is low and a new beat
// may be taken. Reset clears the sequencer and the configuration registers, not the store.
module bilinear_image_resize #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [bir_pkg::COORD_W-1:0]         column,
    input  logic [bir_pkg::COORD_W-1:0]         row,
    input  logic [bir_pkg::CHAN_W-1:0]          red_in,
    input  logic [bir_pkg::CHAN_W-1:0]          green_in,
    input  logic [bir_pkg::CHAN_W-1:0]          blue_in,
    output logic                                done,
    output logic [bir_pkg::CHAN_W-1:0]          red_out,
    output logic [bir_pkg::CHAN_W-1:0]          green_out,
    output logic [bir_pkg::CHAN_W-1:0]          blue_out,
    output logic                                clamped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bir_pkg::STEP_W-1:0]          cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLAMP = 8'b0000_0010,
        ST_RD0   = 8'b0000_0100,
        ST_RD1   = 8'b0000_1000,
        ST_RD2   = 8'b0001_0000,
        ST_RD3   = 8'b0010_0000,
        ST_BOT   = 8'b0100_0000,
        ST_VERT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [bir_pkg::DIM_W-1:0]  width_reg;
    logic [bir_pkg::DIM_W-1:0]  height_reg;
    logic [bir_pkg::STEP_W-1:0] step_x_reg;
    logic [bir_pkg::STEP_W-1:0] step_y_reg;

    logic accept;
    logic query_load;
    logic wr_en;

    logic [XW-1:0]        x1;
    logic [XW-1:0]        x2;
    logic [YW-1:0]        y1;
    logic [YW-1:0]        y2;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] ty;
    logic                 flag_x;
    logic                 flag_y;

    logic [XW-1:0] rd_x;
    logic [YW-1:0] rd_y;
    bir_pkg::pixel_t wr_pixel;
    bir_pkg::pixel_t rd_pixel;

    bir_pkg::pixel_t      hold_reg;
    bir_pkg::pixel_t      top_reg;
    bir_pkg::pixel_t      bot_reg;
    bir_pkg::pixel_t      out_reg;
    logic                 clamped_reg;
    logic                 done_reg;

    bir_pkg::pixel_t      mix_a;
    bir_pkg::pixel_t      mix_b;
    logic [FRAC_BITS-1:0] mix_t;
    bir_pkg::pixel_t      mix_s;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = ~busy;
    assign accept     = start && !busy;
    assign query_load = accept && (opcode == bir_pkg::OP_QUERY);
    assign wr_en      = accept && (opcode == bir_pkg::OP_WRITE)
                        && (32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bir_pkg::DIM_RESET;
            height_reg <= bir_pkg::DIM_RESET;
            step_x_reg <= bir_pkg::STEP_RESET;
            step_y_reg <= bir_pkg::STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bir_pkg::CFG_SOURCE_WIDTH:  width_reg  <= cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::CFG_SOURCE_HEIGHT: height_reg <= cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::CFG_STEP_X:        step_x_reg <= cfg_data;
                bir_pkg::CFG_STEP_Y:        step_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = query_load ? ST_CLAMP : ST_IDLE;
            ST_CLAMP: state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_RD3;
            ST_RD3:   state_next = ST_BOT;
            ST_BOT:   state_next = ST_VERT;
            ST_VERT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_VERT);
        end
    end

    bir_axis_map #(
        .MAX_SIZE  (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_map_x (
        .clk      (clk),
        .load     (query_load),
        .dst      (column),
        .step     (step_x_reg),
        .size_cfg (width_reg),
        .base     (x1),
        .next     (x2),
        .frac     (tx),
        .flag     (flag_x)
    );

    bir_axis_map #(
        .MAX_SIZE  (MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_map_y (
        .clk      (clk),
        .load     (query_load),
        .dst      (row),
        .step     (step_y_reg),
        .size_cfg (height_reg),
        .base     (y1),
        .next     (y2),
        .frac     (ty),
        .flag     (flag_y)
    );

    // The store takes no writes while busy, so reads never meet a write to the same entry.
    always_comb
    begin
        rd_x = x2;
        rd_y = y2;
        unique case (state_reg)
            ST_RD0:
            begin
                rd_x = x1;
                rd_y = y1;
            end
            ST_RD1:
            begin
                rd_x = x2;
                rd_y = y1;
            end
            ST_RD2:
            begin
                rd_x = x1;
                rd_y = y2;
            end
            default:
            begin
                rd_x = x2;
                rd_y = y2;
            end
        endcase
    end

    assign wr_pixel = '{red: red_in, green: green_in, blue: blue_in};

    bir_frame_store #(
        .AW (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({row[YW-1:0], column[XW-1:0]}),
        .wr_data (wr_pixel),
        .rd_addr ({rd_y, rd_x}),
        .rd_data (rd_pixel)
    );

    // One blend unit serves the top row, the bottom row and then the vertical pass.
    always_comb
    begin
        mix_a = top_reg;
        mix_b = bot_reg;
        mix_t = ty;
        unique case (state_reg)
            ST_RD2:
            begin
                mix_a = hold_reg;
                mix_b = rd_pixel;
                mix_t = tx;
            end
            ST_BOT:
            begin
                mix_a = hold_reg;
                mix_b = rd_pixel;
                mix_t = tx;
            end
            default:
            begin
                mix_a = top_reg;
                mix_b = bot_reg;
                mix_t = ty;
            end
        endcase
    end

    bir_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .a (mix_a),
        .b (mix_b),
        .t (mix_t),
        .s (mix_s)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RD1) || (state_reg == ST_RD3))
        begin
            hold_reg <= rd_pixel;
        end
        if (state_reg == ST_RD2)
        begin
            top_reg <= mix_s;
        end
        if (state_reg == ST_BOT)
        begin
            bot_reg <= mix_s;
        end
        if (state_reg == ST_VERT)
        begin
            out_reg     <= mix_s;
            clamped_reg <= flag_x | flag_y;
        end
    end

    assign done      = done_reg;
    assign red_out   = out_reg.red;
    assign green_out = out_reg.green;
    assign blue_out  = out_reg.blue;
    assign clamped   = clamped_reg;

endmodule

FILE: hw/rtl/bir_frame_store.sv
// Single-port-read, single-port-write frame store holding RGB888 source pixels.
// Read data is registered. Depends on bir_pkg.
module bir_frame_store #(
    parameter int AW = 16
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bir_pkg::pixel_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output bir_pkg::pixel_t rd_data
);

    bir_pkg::pixel_t store_mem [0:(1 << AW)-1];
    bir_pkg::pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bir_axis_map.sv
// Maps one destination coordinate to base, next neighbour and fraction.
// Two register stages: the product dst * step, then the clamped results. Uses bir_pkg.
module bir_axis_map #(
    parameter int MAX_SIZE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic [bir_pkg::COORD_W-1:0]       dst,
    input  logic [bir_pkg::STEP_W-1:0]        step,
    input  logic [bir_pkg::DIM_W-1:0]         size_cfg,
    output logic [$clog2(MAX_SIZE)-1:0]       base,
    output logic [$clog2(MAX_SIZE)-1:0]       next,
    output logic [FRAC_BITS-1:0]              frac,
    output logic                              flag
);

    localparam int PW = bir_pkg::COORD_W + bir_pkg::STEP_W;
    localparam int BW = PW - FRAC_BITS;
    localparam int CW = $clog2(MAX_SIZE);
    localparam int DW = bir_pkg::DIM_W;

    logic [PW-1:0]        pos_reg;
    logic [DW-1:0]        size_eff;
    logic [BW-1:0]        base_full;
    logic                 over;
    logic [DW-1:0]        b;
    logic [DW-1:0]        n;
    logic [FRAC_BITS-1:0] f;
    logic [CW-1:0]        base_reg;
    logic [CW-1:0]        next_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic                 flag_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= PW'(dst) * PW'(step);
        end
    end

    always_comb
    begin
        if (size_cfg == '0)
        begin
            size_eff = DW'(1);
        end
        else if (32'(size_cfg) > MAX_SIZE)
        begin
            size_eff = DW'(MAX_SIZE);
        end
        else
        begin
            size_eff = size_cfg;
        end
    end

    // A base beyond the frame is pinned to the last column or row with zero fraction.
    always_comb
    begin
        base_full = pos_reg[PW-1:FRAC_BITS];
        over      = base_full >= BW'(size_eff);
        if (over)
        begin
            b = size_eff - DW'(1);
            f = '0;
        end
        else
        begin
            b = base_full[DW-1:0];
            f = pos_reg[FRAC_BITS-1:0];
        end
        if (({1'b0, b} + (DW+1)'(1)) < {1'b0, size_eff})
        begin
            n = b + DW'(1);
        end
        else
        begin
            n = size_eff - DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= CW'(b);
        next_reg <= CW'(n);
        frac_reg <= f;
        flag_reg <= over;
    end

    assign base = base_reg;
    assign next = next_reg;
    assign frac = frac_reg;
    assign flag = flag_reg;

endmodule

FILE: hw/rtl/bir_blend.sv
// Three-channel linear blend of two pixels with a fixed-point fraction.
// Each product is rounded to nearest and the sum saturates at 255. Uses bir_pkg.
module bir_blend #(
    parameter int FRAC_BITS = 16
) (
    input  bir_pkg::pixel_t      a,
    input  bir_pkg::pixel_t      b,
    input  logic [FRAC_BITS-1:0] t,
    output bir_pkg::pixel_t      s
);

    localparam int PW = FRAC_BITS + 9;
    localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]      HALF = {{(PW-FRAC_BITS){1'b0}}, 1'b1,
                                           {(FRAC_BITS-1){1'b0}}};

    logic [2:0][7:0] av;
    logic [2:0][7:0] bv;
    logic [2:0][7:0] sv;

    function automatic logic [7:0] mix(input logic [7:0] p, input logic [7:0] q,
                                       input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS:0] wq;
        logic [FRAC_BITS:0] wp;
        logic [PW-1:0]      pa;
        logic [PW-1:0]      pb;
        logic [9:0]         sum;
        wq  = {1'b0, frac};
        wp  = ONE - wq;
        pa  = PW'(p) * PW'(wp) + HALF;
        pb  = PW'(q) * PW'(wq) + HALF;
        sum = {1'b0, pa[PW-1:FRAC_BITS]} + {1'b0, pb[PW-1:FRAC_BITS]};
        return (sum > 10'd255) ? 8'hFF : sum[7:0];
    endfunction

    assign av = a;
    assign bv = b;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sv[ch] = mix(av[ch], bv[ch], t);
        end
    end

    assign s = sv;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_image_resize: a directed table, then random phases
// over frame sizes and steps, each result checked by the table or an in-bench predictor.
// Depends on bir_pkg and the bilinear_image_resize top level only.
module tb_top;
    import bir_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int FRAC = 16;
    localparam longint unsigned ONE = 64'd1 << FRAC;
    localparam longint unsigned HALF = 64'd1 << (FRAC - 1);
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 193;
    localparam int SCRIPT_LEN = 23;

    typedef struct packed {
        pixel_t px;
        logic   clamp;
    } resample_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        pixel_t             px;
        logic               typed;
        resample_t          want;
    } probe_t;

    localparam resample_t NO_WANT = '0;

    localparam probe_t SCRIPT [SCRIPT_LEN] = '{
        {OP_WRITE, 16'd0,     16'd0,     24'hFF0080, 1'b0, NO_WANT},
        {OP_WRITE, 16'd1,     16'd0,     24'h00FF7F, 1'b0, NO_WANT},
        {OP_WRITE, 16'd0,     16'd1,     24'h123456, 1'b0, NO_WANT},
        {OP_WRITE, 16'd1,     16'd1,     24'hFFFFFF, 1'b0, NO_WANT},
        {OP_QUERY, 16'd0,     16'd0,     24'h000000, 1'b1, {24'hFF0080, 1'b0}},
        {OP_WRITE, 16'd255,   16'd255,   24'hABCDEF, 1'b0, NO_WANT},
        {OP_QUERY, 16'd255,   16'd255,   24'h000000, 1'b1, {24'hABCDEF, 1'b0}},
        {OP_QUERY, 16'hFFFF,  16'hFFFF,  24'h000000, 1'b1, {24'hABCDEF, 1'b1}},
        {OP_WRITE, 16'd255,   16'd0,     24'h010203, 1'b0, NO_WANT},
        {OP_WRITE, 16'd255,   16'd1,     24'hFEFDFC, 1'b0, NO_WANT},
        {OP_QUERY, 16'hFFFF,  16'd0,     24'h000000, 1'b1, {24'h010203, 1'b1}},
        {OP_WRITE, 16'd0,     16'd255,   24'hC0FFEE, 1'b0, NO_WANT},
        {OP_WRITE, 16'd1,     16'd255,   24'h000000, 1'b0, NO_WANT},
        {OP_QUERY, 16'd0,     16'hFFFF,  24'h000000, 1'b1, {24'hC0FFEE, 1'b1}},
        {OP_WRITE, 16'd256,   16'd0,     24'h111111, 1'b0, NO_WANT},
        {OP_WRITE, 16'd0,     16'd256,   24'h222222, 1'b0, NO_WANT},
        {OP_WRITE, 16'hFFFF,  16'hFFFF,  24'h333333, 1'b0, NO_WANT},
        {OP_QUERY, 16'd0,     16'd0,     24'hFFFFFF, 1'b1, {24'hFF0080, 1'b0}},
        {OP_WRITE, 16'd0,     16'd0,     24'h000000, 1'b0, NO_WANT},
        {OP_QUERY, 16'd0,     16'd0,     24'h000000, 1'b1, {24'h000000, 1'b0}},
        {OP_WRITE, 16'd2,     16'd0,     24'h804020, 1'b0, NO_WANT},
        {OP_WRITE, 16'd2,     16'd1,     24'h102030, 1'b0, NO_WANT},
        {OP_QUERY, 16'd1,     16'd0,     24'h5A5A5A, 1'b0, NO_WANT}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               opcode = OP_WRITE;
    logic [COORD_W-1:0] column = '0;
    logic [COORD_W-1:0] row = '0;
    logic [CHAN_W-1:0]  red_in = '0;
    logic [CHAN_W-1:0]  green_in = '0;
    logic [CHAN_W-1:0]  blue_in = '0;
    logic               done;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic               clamped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]  cfg_data = '0;

    pixel_t             pixel_mem [MAX_W*MAX_H];
    bit                 pixel_set [MAX_W*MAX_H];
    logic [DIM_W-1:0]   src_w = DIM_RESET;
    logic [DIM_W-1:0]   src_h = DIM_RESET;
    logic [STEP_W-1:0]  step_col = STEP_RESET;
    logic [STEP_W-1:0]  step_row = STEP_RESET;
    resample_t          pending [$];
    bit                 steady = 1'b0;
    int                 errors = 0;
    int                 queries_sent = 0;
    int                 writes_sent = 0;
    int                 writes_dropped = 0;
    int                 results_seen = 0;
    int                 clamped_seen = 0;

    bilinear_image_resize #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H),
        .FRAC_BITS(FRAC)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .column(column),
        .row(row),
        .red_in(red_in),
        .green_in(green_in),
        .blue_in(blue_in),
        .done(done),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .clamped(clamped),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input longint unsigned t);
        longint unsigned pa;
        longint unsigned pb;
        pa = (64'(a) * (ONE - t) + HALF) >> FRAC;
        pb = (64'(b) * t + HALF) >> FRAC;
        if (pa + pb > 255) return 8'hFF;
        return 8'(pa + pb);
    endfunction

    function automatic bit map_axis(input logic [COORD_W-1:0] dst, input logic [STEP_W-1:0] stp,
                                    input int size, output int base, output int nxt,
                                    output longint unsigned frac);
        longint unsigned pos;
        bit flag;
        pos = 64'(dst) * 64'(stp);
        flag = 1'b0;
        if ((pos >> FRAC) >= 64'(size))
        begin
            base = size - 1;
            frac = 0;
            flag = 1'b1;
        end
        else
        begin
            base = int'(pos >> FRAC);
            frac = pos & (ONE - 1);
        end
        nxt = (base + 1 < size) ? base + 1 : size - 1;
        return flag;
    endfunction

    function automatic resample_t resample(input logic [COORD_W-1:0] dc,
                                           input logic [COORD_W-1:0] dr);
        int x1, x2, y1, y2;
        longint unsigned tx, ty;
        bit fx, fy;
        pixel_t p11, p12, p21, p22;
        resample_t r;
        fx = map_axis(dc, step_col, eff_dim(src_w, MAX_W), x1, x2, tx);
        fy = map_axis(dr, step_row, eff_dim(src_h, MAX_H), y1, y2, ty);
        p11 = pixel_mem[y1*MAX_W + x1];
        p12 = pixel_mem[y1*MAX_W + x2];
        p21 = pixel_mem[y2*MAX_W + x1];
        p22 = pixel_mem[y2*MAX_W + x2];
        r.px.red   = mix(mix(p11.red, p12.red, tx), mix(p21.red, p22.red, tx), ty);
        r.px.green = mix(mix(p11.green, p12.green, tx), mix(p21.green, p22.green, tx), ty);
        r.px.blue  = mix(mix(p11.blue, p12.blue, tx), mix(p21.blue, p22.blue, tx), ty);
        r.clamp = fx | fy;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAN_W-1:0] random_chan();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) return 8'hFF;
        if (roll == 3) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_t random_pixel();
        return {random_chan(), random_chan(), random_chan()};
    endfunction

    function automatic logic [COORD_W-1:0] pick_dst(input logic [STEP_W-1:0] stp, input int size);
        longint unsigned lim;
        if (stp == 0 || $urandom_range(0, 9) == 0) return 16'($urandom_range(0, 16'hFFFF));
        lim = ((64'(size) + 1) << FRAC) / 64'(stp) + 1;
        if (lim > 16'hFFFF) lim = 16'hFFFF;
        return 16'($urandom_range(0, int'(lim)));
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic drive_item(input logic op, input logic [COORD_W-1:0] c,
                              input logic [COORD_W-1:0] r, input pixel_t px,
                              input logic typed, input resample_t want);
        int gap;
        start <= 1'b1;
        opcode <= op;
        column <= c;
        row <= r;
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        do @(posedge clk); while (busy);
        if (op == OP_QUERY)
        begin
            pending.push_back(typed ? want : resample(c, r));
            queries_sent++;
        end
        else if (c < MAX_W && r < MAX_H)
        begin
            pixel_mem[r*MAX_W + c] = px;
            pixel_set[r*MAX_W + c] = 1'b1;
            writes_sent++;
        end
        else
        begin
            writes_dropped++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        int gap;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SOURCE_WIDTH:  src_w = val[DIM_W-1:0];
            CFG_SOURCE_HEIGHT: src_h = val[DIM_W-1:0];
            CFG_STEP_X:        step_col = val;
            CFG_STEP_Y:        step_row = val;
            default: ;
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy);
        write_reg(CFG_SOURCE_WIDTH, {15'($urandom_range(0, 16'h7FFF)), w});
        write_reg(CFG_SOURCE_HEIGHT, {15'($urandom_range(0, 16'h7FFF)), h});
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Every pixel a query will fetch is stored first, so no unwritten entry is ever read.
    task automatic fill_corners(input logic [COORD_W-1:0] dc, input logic [COORD_W-1:0] dr);
        int xs [2];
        int ys [2];
        longint unsigned fr;
        int i;
        void'(map_axis(dc, step_col, eff_dim(src_w, MAX_W), xs[0], xs[1], fr));
        void'(map_axis(dr, step_row, eff_dim(src_h, MAX_H), ys[0], ys[1], fr));
        for (i = 0; i < 4; i++)
        begin
            if (!pixel_set[ys[i/2]*MAX_W + xs[i%2]])
                drive_item(OP_WRITE, 16'(xs[i%2]), 16'(ys[i/2]), random_pixel(), 1'b0, NO_WANT);
        end
    endtask

    task automatic run_phase(input int quota);
        int base_count, sent, roll, w, h;
        bit paused;
        logic [COORD_W-1:0] dc, dr;
        base_count = queries_sent + writes_sent;
        sent = 0;
        paused = 1'b0;
        w = eff_dim(src_w, MAX_W);
        h = eff_dim(src_h, MAX_H);
        while (sent < quota)
        begin
            if ($urandom_range(0, 39) == 0) steady = ($urandom_range(0, 2) == 0);
            if ((!paused && sent >= quota / 2) || $urandom_range(0, 99) == 0)
            begin
                paused = 1'b1;
                start <= 1'b0;
                while (pending.size() != 0) @(posedge clk);
                @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 7)
                begin
                    dc = 16'($urandom_range(0, w - 1));
                    dr = 16'($urandom_range(0, h - 1));
                end
                else if (roll < 9)
                begin
                    dc = 16'($urandom_range(0, MAX_W - 1));
                    dr = 16'($urandom_range(0, MAX_H - 1));
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    dc = 16'($urandom_range(MAX_W, 16'hFFFF));
                    dr = 16'($urandom_range(0, 16'hFFFF));
                end
                else
                begin
                    dc = 16'($urandom_range(0, 16'hFFFF));
                    dr = 16'($urandom_range(MAX_H, 16'hFFFF));
                end
                drive_item(OP_WRITE, dc, dr, random_pixel(), 1'b0, NO_WANT);
            end
            else
            begin
                dc = pick_dst(step_col, w);
                dr = pick_dst(step_row, h);
                fill_corners(dc, dr);
                drive_item(OP_QUERY, dc, dr, random_pixel(), 1'b0, NO_WANT);
            end
            sent = queries_sent + writes_sent - base_count;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        resample_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (clamped === 1'b1) clamped_seen++;
            if (pending.size() == 0)
            begin
                report("result with no query outstanding");
            end
            else
            begin
                want = pending.pop_front();
                if (red_out !== want.px.red)
                    report($sformatf("red_out %0h, expected %0h", red_out, want.px.red));
                if (green_out !== want.px.green)
                    report($sformatf("green_out %0h, expected %0h", green_out, want.px.green));
                if (blue_out !== want.px.blue)
                    report($sformatf("blue_out %0h, expected %0h", blue_out, want.px.blue));
                if (clamped !== want.clamp)
                    report($sformatf("clamped %0b, expected %0b", clamped, want.clamp));
            end
        end
    end

    initial
    begin : stimulus
        int i, k;
        logic [DIM_W-1:0] w, h;
        logic [STEP_W-1:0] sx, sy;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < SCRIPT_LEN; i++)
            drive_item(SCRIPT[i].op, SCRIPT[i].col, SCRIPT[i].row, SCRIPT[i].px,
                       SCRIPT[i].typed, SCRIPT[i].want);
        start <= 1'b0;
        settle();

        for (k = 0; k < PHASES; k++)
        begin
            case (k)
                0:
                begin
                    w = 9'd256;
                    h = 9'd256;
                    sx = 24'h010000;
                    sy = 24'h010000;
                end
                1:
                begin
                    w = 9'd1;
                    h = 9'd1;
                    sx = 24'h018000;
                    sy = 24'h00C000;
                end
                2:
                begin
                    w = 9'd0;
                    h = 9'd511;
                    sx = 24'h004000;
                    sy = 24'h008000;
                end
                3:
                begin
                    w = 9'd256;
                    h = 9'd1;
                    sx = 24'h008000;
                    sy = 24'h008000;
                end
                4:
                begin
                    w = 9'd16;
                    h = 9'd12;
                    sx = 24'h000000;
                    sy = 24'h000000;
                end
                5:
                begin
                    w = 9'd20;
                    h = 9'd20;
                    sx = 24'hFFFFFF;
                    sy = 24'hFFFFFF;
                end
                6:
                begin
                    w = 9'd33;
                    h = 9'd7;
                    sx = 24'h013333;
                    sy = 24'h00CCCD;
                end
                7:
                begin
                    w = 9'($urandom_range(1, 256));
                    h = 9'($urandom_range(1, 256));
                    sx = 24'($urandom_range(0, 24'hFFFFFF));
                    sy = 24'($urandom_range(0, 24'h040000));
                end
                default:
                begin
                    w = 9'($urandom_range(2, 24));
                    h = 9'($urandom_range(2, 24));
                    sx = 24'($urandom_range(24'h002000, 24'h030000));
                    sy = 24'($urandom_range(24'h002000, 24'h030000));
                end
            endcase
            configure(w, h, sx, sy);
            run_phase(PHASE_ITEMS);
            start <= 1'b0;
            settle();
        end

        $display("Checked %0d resampled pixels (%0d clamped) against %0d stored pixel writes",
                 results_seen, clamped_seen, writes_sent);
        $display("and %0d dropped writes, over %0d frame and step settings from 1x1 to 256x256.",
                 writes_dropped, PHASES + 1);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Timeout with %0d results outstanding", pending.size());
        $display("Verification failed");
        $finish;
    end

endmodule
